FILE: rtl/core/cbp_pkg.sv
// shared constants for the cubic bezier point evaluator
package cbp_pkg;

  // control points per curve and coordinate axes per point
  localparam int NUM_PTS   = 4;
  localparam int NUM_AXES  = 2;
  localparam int NUM_LANES = NUM_PTS * NUM_AXES;

  // pipeline depth from the input register to the last merge register
  localparam int PIPE_DEPTH = 7;

endpackage

FILE: rtl/core/cbp_weights.sv
// bernstein weight generator: saturates t, forms u and the four cubic weights
module cbp_weights
  import cbp_pkg::*;
#(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      en,
  input  logic [T_FRAC_BITS:0]                      t_in,
  output logic [NUM_PTS-1:0][3*T_FRAC_BITS:0]       weight_o
);

  localparam int TW = T_FRAC_BITS + 1;
  localparam int WW = 3 * T_FRAC_BITS + 1;
  localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  // stage 1: saturated t and u = 1 - t
  logic [TW-1:0] t1_r, u1_r;
  logic [TW-1:0] t_sat;

  assign t_sat = (t_in > T_ONE) ? T_ONE : t_in;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t_sat;
      u1_r <= T_ONE - t_sat;
    end
  end

  // stage 2: second-order products
  logic [2*TW-1:0] uu2_r, ut2_r, tt2_r;
  logic [TW-1:0]   t2_r, u2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      uu2_r <= u1_r * u1_r;
      ut2_r <= u1_r * t1_r;
      tt2_r <= t1_r * t1_r;
      t2_r  <= t1_r;
      u2_r  <= u1_r;
    end
  end

  // stage 3: third-order products, times three for the middle weights
  logic [3*TW-1:0] uuu, uut, utt, ttt;
  logic [3*TW-1:0] uut3, utt3;
  logic [NUM_PTS-1:0][WW-1:0] w_r;

  assign uuu  = uu2_r * u2_r;
  assign uut  = uu2_r * t2_r;
  assign utt  = ut2_r * t2_r;
  assign ttt  = tt2_r * t2_r;
  assign uut3 = uut + {uut[3*TW-2:0], 1'b0};
  assign utt3 = utt + {utt[3*TW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      w_r[0] <= uuu[WW-1:0];
      w_r[1] <= uut3[WW-1:0];
      w_r[2] <= utt3[WW-1:0];
      w_r[3] <= ttt[WW-1:0];
    end
  end

  assign weight_o = w_r;

endmodule

FILE: rtl/core/cbp_lane.sv
// one lane: delays a coordinate to meet its weight and forms the exact weighted term
module cbp_lane
  import cbp_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [COORD_WIDTH-1:0]                 coord_in,
  input  logic [3*T_FRAC_BITS:0]                 weight_in,
  output logic [3*T_FRAC_BITS+COORD_WIDTH:0]     term_o
);

  localparam int CW = COORD_WIDTH;
  localparam int WW = 3 * T_FRAC_BITS + 1;
  localparam int WL = (WW + 1) / 2;
  localparam int WH = WW - WL;
  localparam int PW = WW + CW;

  // coordinate delay matching the weight generator
  logic signed [CW-1:0] c1_r, c2_r, c3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= coord_in;
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  // stage 4: weight split in two halves, each times the coordinate
  logic signed [WL:0]        wl_s;
  logic signed [WH:0]        wh_s;
  logic signed [WL+CW:0]     plo_r;
  logic signed [WH+CW:0]     phi_r;

  assign wl_s = {1'b0, weight_in[WL-1:0]};
  assign wh_s = {1'b0, weight_in[WW-1:WL]};

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r <= wl_s * c3_r;
      phi_r <= wh_s * c3_r;
    end
  end

  // stage 5: recombine the partial products
  logic signed [PW-1:0] lo_ext, hi_ext, term_r;

  assign lo_ext = {{(PW-(WL+1+CW)){plo_r[WL+CW]}}, plo_r};
  assign hi_ext = {{(PW-(WH+1+CW)){phi_r[WH+CW]}}, phi_r};

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= (hi_ext << WL) + lo_ext;
    end
  end

  assign term_o = term_r;

endmodule

FILE: rtl/core/cbp_merge.sv
// merge stage: sums the lane terms per axis, rounds and saturates
module cbp_merge
  import cbp_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                                 clk,
  input  logic                                                 en,
  input  logic [NUM_LANES-1:0][3*T_FRAC_BITS+COORD_WIDTH:0]    term_in,
  output logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                 point_o
);

  localparam int CW    = COORD_WIDTH;
  localparam int SCALE = 3 * T_FRAC_BITS;
  localparam int PW    = SCALE + 1 + CW;
  localparam int AW    = PW + 2;
  localparam logic [AW-1:0] HALF = {{(AW-1){1'b0}}, 1'b1} << (SCALE - 1);
  localparam logic [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MIN_C = {1'b1, {(CW-1){1'b0}}};

  genvar a;
  generate
    for (a = 0; a < NUM_AXES; a++) begin : g_axis
      logic [AW-1:0] e0, e1, e2, e3;
      logic [AW-1:0] pa_r, pb_r, tot_r;
      logic [AW-1:SCALE+CW-1] top;
      logic                   in_range;

      // lane order is point-major, x then y
      assign e0 = {{2{term_in[a][PW-1]}}, term_in[a]};
      assign e1 = {{2{term_in[NUM_AXES+a][PW-1]}}, term_in[NUM_AXES+a]};
      assign e2 = {{2{term_in[2*NUM_AXES+a][PW-1]}}, term_in[2*NUM_AXES+a]};
      assign e3 = {{2{term_in[3*NUM_AXES+a][PW-1]}}, term_in[3*NUM_AXES+a]};

      // stage 6: pair sums
      always_ff @(posedge clk) begin
        if (en) begin
          pa_r <= e0 + e1;
          pb_r <= e2 + e3;
        end
      end

      // stage 7: total plus rounding half
      always_ff @(posedge clk) begin
        if (en) begin
          tot_r <= pa_r + pb_r + HALF;
        end
      end

      // drop fraction, clamp when the upper bits are not a sign extension
      assign top      = tot_r[AW-1:SCALE+CW-1];
      assign in_range = (top == '0) || (top == '1);
      assign point_o[a] = in_range ? tot_r[SCALE+CW-1:SCALE]
                                   : (tot_r[AW-1] ? MIN_C : MAX_C);
    end
  endgenerate

endmodule

FILE: rtl/core/cubic_bezier_point.sv
// cubic bezier point evaluator top level: weight generator, lanes, merge and output buffer
//
// evaluates one point of a 2d cubic bezier curve for each input word: the word
// carries t (unsigned q1.T_FRAC_BITS, values above one are clamped to one) and
// four control points p0..p3 (signed COORD_WIDTH-bit coordinates, q16.8 by
// default). the bernstein weights u^3, 3u^2t, 3ut^2 and t^3 are formed exactly,
// eight lanes (one per point and axis) multiply their coordinate by its weight
// exactly, and a merge stage adds the four terms per axis, rounds to nearest
// (ties toward plus infinity) and saturates to the coordinate range. the block
// is fully pipelined: one word in and one point out per clock while in_tready and
// out_tready stay high. an accepted word passes the first of three weight stages,
// then two lane stages (multiply and recombine), two merge adder stages and
// finally the output register.
// a two-entry output buffer keeps the input side accepting while a result
// waits; in_tready drops only while both entries are full.
module cubic_bezier_point
  import cbp_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int T_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  // slave side
  input  logic in_tvalid,
  output logic in_tready,
  // t_param, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, zero pad
  input  logic [((T_FRAC_BITS+1+8*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  // master side
  output logic out_tvalid,
  input  logic out_tready,
  // point_x, point_y, zero pad
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] out_tdata
);

  localparam int CW    = COORD_WIDTH;
  localparam int TW    = T_FRAC_BITS + 1;
  localparam int WW    = 3 * T_FRAC_BITS + 1;
  localparam int PW    = WW + CW;
  localparam int OUT_W = ((2*COORD_WIDTH+7)/8)*8;

  // pipeline enable: everything advances unless the skid entry is occupied
  logic en;
  logic skid_valid_r, skid_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [2*CW-1:0] skid_data_r, out_data_r;

  assign en        = ~skid_valid_r;
  assign in_tready = en;

  // valid bit per pipeline stage
  logic [PIPE_DEPTH-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  // weight generator
  logic [NUM_PTS-1:0][WW-1:0] weight;

  cbp_weights #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_weights (
    .clk     (clk),
    .en      (en),
    .t_in    (in_tdata[TW-1:0]),
    .weight_o(weight)
  );

  // one lane per control point coordinate, x then y for each point
  logic [NUM_LANES-1:0][PW-1:0] term;

  genvar k;
  generate
    for (k = 0; k < NUM_LANES; k++) begin : g_lane
      cbp_lane #(
        .COORD_WIDTH(COORD_WIDTH),
        .T_FRAC_BITS(T_FRAC_BITS)
      ) u_lane (
        .clk      (clk),
        .en       (en),
        .coord_in (in_tdata[TW+k*CW +: CW]),
        .weight_in(weight[k/NUM_AXES]),
        .term_o   (term[k])
      );
    end
  endgenerate

  // per-axis sum, round and clamp
  logic [NUM_AXES-1:0][CW-1:0] point;

  cbp_merge #(
    .COORD_WIDTH(COORD_WIDTH),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_merge (
    .clk    (clk),
    .en     (en),
    .term_in(term),
    .point_o(point)
  );

  // result leaves the last stage whenever the pipeline moves
  logic push;
  assign push = en & vld_r[PIPE_DEPTH-1];

  // output register plus skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_valid_r && !out_tready) begin
      if (push) begin
        skid_valid_nxt = 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_tready) begin
      if (push) begin
        skid_data_r <= {point[1], point[0]};
      end
    end else if (skid_valid_r) begin
      out_data_r <= skid_data_r;
    end else if (push) begin
      out_data_r <= {point[1], point[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

endmodule
